// ----- rtl/uhws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhws_pkg
// Shared types and constants for the usage history window stats unit.
// ----------------------------------------------------------------------------
package uhws_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;

    localparam int SAMPLE_W   = 16;
    localparam int INTERVAL_W = 8;
    localparam int THRESH_W   = 16;
    localparam int WINDOW_W   = 16;
    localparam int AGE_W      = 6;
    localparam int TREND_W    = 2;

    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 72;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam int TREND_SAMPLES = 3;

    localparam logic [0:0] MODE_RECORD = 1'b0;
    localparam logic [0:0] MODE_QUERY  = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 1'b1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 8'd5;
    localparam logic [THRESH_W-1:0]   THRESH_RST   = 16'd100;

    localparam logic [TREND_W-1:0] TREND_FLAT = 2'd0;
    localparam logic [TREND_W-1:0] TREND_INC  = 2'd1;
    localparam logic [TREND_W-1:0] TREND_DEC  = 2'd2;
    localparam logic [TREND_W-1:0] TREND_NA   = 2'd3;

    // result word bit positions
    localparam int OUT_AVG_CPU_LSB   = 0;
    localparam int OUT_AVG_MEM_LSB   = 16;
    localparam int OUT_AVG_VALID     = 32;
    localparam int OUT_TREND_LSB     = 33;
    localparam int OUT_ENTRY_CPU_LSB = 35;
    localparam int OUT_ENTRY_MEM_LSB = 51;
    localparam int OUT_ENTRY_VALID   = 67;

endpackage

// ----- rtl/uhws_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhws_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uhws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/uhws_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhws_div
// Restoring unsigned divider, one quotient bit per cycle. Divisor nonzero.
// ----------------------------------------------------------------------------
module uhws_div #(
    parameter int DW = 16,
    parameter int VW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic          done
);

    localparam int CNTW = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [VW-1:0]   dvs_reg, dvs_next;

    logic [VW:0] rem_sh;
    logic [VW:0] diff;
    logic        ge;

    assign rem_sh = {rem_reg, quo_reg[DW-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(DW);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- rtl/usage_history_window_stats_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usage_history_window_stats_unit
// Ring history of CPU/memory samples with windowed averages, trend and
// read-back by age.
// ----------------------------------------------------------------------------
// A record transaction (tuser 0) writes one sample pair into the history RAM;
// the slave side is ready again right after. A query transaction (tuser 1)
// returns one result: a bit-serial divider divides the window by the sample
// interval in 16 steps, then the entries are walked through the single RAM
// read port, newest first, up to the largest of the window count, three and
// read_age + 1, each as far as the store is filled. The two bit-serial
// average dividers start on the last read data, and their quotients are
// loaded into the output register. An empty store skips the walk and the
// averages. The slave side stays low while a query is in flight; a finished
// result waits in the output register.
// ----------------------------------------------------------------------------
module usage_history_window_stats_unit
    import uhws_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // cpu_usage, mem_usage, window_seconds, read_age
    input  logic                  s_axis_tuser,  // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // avg_cpu, avg_mem, avg_valid, trend_code,
                                                 // entry_cpu, entry_mem, entry_valid
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = SAMPLE_W + FW;
    localparam int CW = (FW > AGE_W + 1) ? FW : AGE_W + 1;
    localparam int NW = (FW > WINDOW_W) ? FW : WINDOW_W;

    localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(HISTORY_DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIVN = 3'd1;
    localparam logic [2:0] ST_WALK = 3'd2;
    localparam logic [2:0] ST_DIVA = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // control
    logic [2:0]            state_reg, state_next;
    logic [AW-1:0]         wp_reg, wp_next;
    logic [FW-1:0]         fill_reg, fill_next;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;
    logic [THRESH_W-1:0]   thresh_reg, thresh_next;
    logic [FW-1:0]         issue_reg, issue_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    // datapath
    logic [AGE_W-1:0]      age_reg, age_next;
    logic [FW-1:0]         n_reg, n_next;
    logic [FW-1:0]         m_reg, m_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]         rd_age_reg, rd_age_next;
    logic [SW-1:0]         sum_c_reg, sum_c_next;
    logic [SW-1:0]         sum_m_reg, sum_m_next;
    logic [SAMPLE_W-1:0]   r0_reg, r0_next;
    logic [SAMPLE_W-1:0]   r1_reg, r1_next;
    logic [SAMPLE_W-1:0]   r2_reg, r2_next;
    logic [SAMPLE_W-1:0]   ent_c_reg, ent_c_next;
    logic [SAMPLE_W-1:0]   ent_m_reg, ent_m_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [SAMPLE_W-1:0]   in_cpu;
    logic [SAMPLE_W-1:0]   in_mem;
    logic [WINDOW_W-1:0]   in_win;
    logic [AGE_W-1:0]      in_age;
    logic                  acc;
    logic                  rec_acc;
    logic                  qry_acc;

    logic                  ram_we;
    logic [2*SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0]   rd_cpu;
    logic [SAMPLE_W-1:0]   rd_mem;

    logic [INTERVAL_W-1:0] divisor_n;
    logic [WINDOW_W-1:0]   qn;
    logic                  qn_done;
    logic [SW-1:0]         q_c;
    logic [SW-1:0]         q_m;
    logic                  qa_done_c;
    logic                  qa_done_m;
    logic                  qa_done;
    logic                  avg_start;

    logic [WINDOW_W-1:0]   n_lo;
    logic [FW-1:0]         n_fit;
    logic [FW-1:0]         trend_need;
    logic                  age_ok;
    logic [FW-1:0]         ent_need;
    logic [FW-1:0]         m_tmp;
    logic                  issuing;
    logic                  last_data;

    logic signed [SAMPLE_W:0] d1;
    logic signed [SAMPLE_W:0] d2;
    logic signed [SAMPLE_W:0] th;
    logic [TREND_W-1:0]    trend;
    logic                  avg_v;
    logic                  ent_v;

    assign in_cpu  = s_axis_tdata[15:0];
    assign in_mem  = s_axis_tdata[31:16];
    assign in_win  = s_axis_tdata[47:32];
    assign in_age  = s_axis_tdata[53:48];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc     = s_axis_tvalid && s_axis_tready;
    assign rec_acc = acc && (s_axis_tuser == MODE_RECORD);
    assign qry_acc = acc && (s_axis_tuser == MODE_QUERY);
    assign ram_we  = rec_acc;

    assign rd_cpu = ram_rdata[SAMPLE_W-1:0];
    assign rd_mem = ram_rdata[2*SAMPLE_W-1:SAMPLE_W];

    assign divisor_n = (interval_reg == '0) ? INTERVAL_W'(1) : interval_reg;

    uhws_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata ({in_mem, in_cpu}),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    uhws_div #(
        .DW (WINDOW_W),
        .VW (INTERVAL_W)
    ) u_div_n (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (qry_acc),
        .dividend (in_win),
        .divisor  (divisor_n),
        .quotient (qn),
        .done     (qn_done)
    );

    uhws_div #(
        .DW (SW),
        .VW (FW)
    ) u_div_c (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (avg_start),
        .dividend (sum_c_next),
        .divisor  (n_reg),
        .quotient (q_c),
        .done     (qa_done_c)
    );

    uhws_div #(
        .DW (SW),
        .VW (FW)
    ) u_div_m (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (avg_start),
        .dividend (sum_m_next),
        .divisor  (n_reg),
        .quotient (q_m),
        .done     (qa_done_m)
    );

    assign qa_done = qa_done_c && qa_done_m;

    // window count clamp and walk length
    assign n_lo       = (qn == '0) ? WINDOW_W'(1) : qn;
    assign n_fit      = (NW'(n_lo) > NW'(fill_reg)) ? fill_reg : FW'(n_lo);
    assign trend_need = (fill_reg >= FW'(TREND_SAMPLES)) ? FW'(TREND_SAMPLES) : '0;
    assign age_ok     = CW'(age_reg) < CW'(fill_reg);
    assign ent_need   = age_ok ? FW'(CW'(age_reg) + CW'(1)) : '0;
    assign m_tmp      = (n_fit > trend_need) ? n_fit : trend_need;

    assign issuing    = (state_reg == ST_WALK) && (issue_reg != m_reg);
    assign last_data  = (state_reg == ST_WALK) && rd_vld_reg
                        && (rd_age_reg == m_reg - FW'(1));
    assign avg_start  = last_data;

    // memory trend from the three newest samples
    assign d1 = $signed({1'b0, r0_reg}) - $signed({1'b0, r1_reg});
    assign d2 = $signed({1'b0, r1_reg}) - $signed({1'b0, r2_reg});
    assign th = $signed({1'b0, thresh_reg});

    always_comb
    begin
        if (fill_reg < FW'(TREND_SAMPLES))
        begin
            trend = TREND_NA;
        end
        else if ((d1 > th) && (d2 > th))
        begin
            trend = TREND_INC;
        end
        else if ((d1 < -th) && (d2 < -th))
        begin
            trend = TREND_DEC;
        end
        else
        begin
            trend = TREND_FLAT;
        end
    end

    assign avg_v = (fill_reg != '0);
    assign ent_v = age_ok;

    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        interval_next = interval_reg;
        thresh_next   = thresh_reg;
        issue_next    = issue_reg;
        rd_vld_next   = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        age_next      = age_reg;
        n_next        = n_reg;
        m_next        = m_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_age_next   = rd_age_reg;
        sum_c_next    = sum_c_reg;
        sum_m_next    = sum_m_reg;
        r0_next       = r0_reg;
        r1_next       = r1_reg;
        r2_next       = r2_reg;
        ent_c_next    = ent_c_reg;
        ent_m_next    = ent_m_reg;
        m_tdata_next  = m_tdata_reg;

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_INTERVAL:  interval_next = cfg_wdata[INTERVAL_W-1:0];
                REG_THRESHOLD: thresh_next   = cfg_wdata[THRESH_W-1:0];
                default:       ;
            endcase
        end

        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (rd_vld_reg && (state_reg == ST_WALK))
        begin
            if (rd_age_reg < n_reg)
            begin
                sum_c_next = sum_c_reg + SW'(rd_cpu);
                sum_m_next = sum_m_reg + SW'(rd_mem);
            end
            if (rd_age_reg == FW'(0))
            begin
                r0_next = rd_mem;
            end
            if (rd_age_reg == FW'(1))
            begin
                r1_next = rd_mem;
            end
            if (rd_age_reg == FW'(2))
            begin
                r2_next = rd_mem;
            end
            if (CW'(rd_age_reg) == CW'(age_reg))
            begin
                ent_c_next = rd_cpu;
                ent_m_next = rd_mem;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (rec_acc)
                begin
                    wp_next = (wp_reg == LAST_SLOT) ? '0 : wp_reg + AW'(1);
                    if (fill_reg != FILL_MAX)
                    begin
                        fill_next = fill_reg + FW'(1);
                    end
                end
                else if (qry_acc)
                begin
                    age_next   = in_age;
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN:
            begin
                if (qn_done)
                begin
                    n_next      = n_fit;
                    m_next      = (ent_need > m_tmp) ? ent_need : m_tmp;
                    issue_next  = '0;
                    rd_ptr_next = (wp_reg == '0) ? LAST_SLOT : wp_reg - AW'(1);
                    sum_c_next  = '0;
                    sum_m_next  = '0;
                    state_next  = (fill_reg == '0) ? ST_OUT : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (issuing)
                begin
                    issue_next  = issue_reg + FW'(1);
                    rd_ptr_next = (rd_ptr_reg == '0) ? LAST_SLOT : rd_ptr_reg - AW'(1);
                    rd_vld_next = 1'b1;
                    rd_age_next = issue_reg;
                end
                if (last_data)
                begin
                    state_next = ST_DIVA;
                end
            end
            ST_DIVA:
            begin
                if (qa_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0,
                                     ent_v,
                                     ent_v ? ent_m_reg : SAMPLE_W'(0),
                                     ent_v ? ent_c_reg : SAMPLE_W'(0),
                                     trend,
                                     avg_v,
                                     avg_v ? q_m[SAMPLE_W-1:0] : SAMPLE_W'(0),
                                     avg_v ? q_c[SAMPLE_W-1:0] : SAMPLE_W'(0)};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            fill_reg     <= '0;
            interval_reg <= INTERVAL_RST;
            thresh_reg   <= THRESH_RST;
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            interval_reg <= interval_next;
            thresh_reg   <= thresh_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        age_reg     <= age_next;
        n_reg       <= n_next;
        m_reg       <= m_next;
        rd_ptr_reg  <= rd_ptr_next;
        rd_age_reg  <= rd_age_next;
        sum_c_reg   <= sum_c_next;
        sum_m_reg   <= sum_m_next;
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        r2_reg      <= r2_next;
        ent_c_reg   <= ent_c_next;
        ent_m_reg   <= ent_m_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

// ----- rtl/uhws_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhws_checker
// Port-level checks for the usage history window stats unit.
// ----------------------------------------------------------------------------
module uhws_checker
    import uhws_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a query blocks the slave side while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_axis_tuser == MODE_QUERY) |=> !s_axis_tready)
        else $error("slave ready during query");

    // a record leaves the slave side ready in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_axis_tuser == MODE_RECORD) |=> s_axis_tready)
        else $error("slave not ready after record");

    // a new result only comes out of a query in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without query");

    // invalid fields read as zero; without averages the trend reads as not available
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[OUT_AVG_VALID]
             || ((m_axis_tdata[OUT_AVG_VALID-1:0] == '0)
                 && (m_axis_tdata[OUT_TREND_LSB+1:OUT_TREND_LSB] == TREND_NA)))
            && (m_axis_tdata[OUT_ENTRY_VALID]
                || (m_axis_tdata[OUT_ENTRY_VALID-1:OUT_ENTRY_CPU_LSB] == '0)))
        else $error("invalid result fields not cleared");

endmodule

bind usage_history_window_stats_unit uhws_checker u_uhws_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/tb_usage_history_window_stats_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usage_history_window_stats_unit
// Self-checking bench for the usage history window stats unit. A short
// directed table covers the empty store, single and two-sample windows,
// threshold edges and the three trend directions. Random phases follow, each
// under a new interval/threshold setting. Most records form memory ramps so
// that trend detection is exercised, and the store fills and wraps. Each
// query result is checked field by field against an internal model of the
// history ring. Both stream sides idle in random bursts in some phases, and
// the result side holds off once for a long stretch so the input backs up.
// ----------------------------------------------------------------------------
module tb_usage_history_window_stats_unit;
    import uhws_pkg::*;

    localparam int DEPTH         = HISTORY_DEPTH_DEF;
    localparam int CLK_HALF      = 10;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 500;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_PHASES    = 5;

    typedef struct packed {
        logic [SAMPLE_W-1:0] avg_cpu;
        logic [SAMPLE_W-1:0] avg_mem;
        logic                avg_valid;
        logic [TREND_W-1:0]  trend_code;
        logic [SAMPLE_W-1:0] entry_cpu;
        logic [SAMPLE_W-1:0] entry_mem;
        logic                entry_valid;
    } window_stats_t;

    typedef struct packed {
        logic [0:0]          mode;
        logic [SAMPLE_W-1:0] cpu;
        logic [SAMPLE_W-1:0] mem;
        logic [WINDOW_W-1:0] window;
        logic [AGE_W-1:0]    age;
        logic                has_golden;
        window_stats_t       golden;
    } stim_row_t;

    localparam window_stats_t NO_GOLDEN   = '0;
    localparam window_stats_t EMPTY_STATS =
        {16'd0, 16'd0, 1'b0, TREND_NA, 16'd0, 16'd0, 1'b0};

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // cpu_usage, mem_usage, window_seconds, read_age
    logic                  s_axis_tuser;   // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // avg_cpu, avg_mem, avg_valid, trend_code,
                                           // entry_cpu, entry_mem, entry_valid
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // history model
    logic [SAMPLE_W-1:0]   ring_cpu [DEPTH];
    logic [SAMPLE_W-1:0]   ring_mem [DEPTH];
    int                    ring_wr;
    int                    ring_fill;
    logic [INTERVAL_W-1:0] cfg_interval;
    logic [THRESH_W-1:0]   cfg_threshold;

    window_stats_t         expected_stats [$];

    bit src_idle_on;
    bit sink_idle_on;
    int hold_reqs;
    int hold_served;
    int ramp_dir;
    int ramp_left;

    int n_records;
    int n_queries;
    int n_checked;
    int n_mismatch;
    int n_settings;
    int trend_hits [4];

    usage_history_window_stats_unit #(
        .HISTORY_DEPTH (DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int age_slot(input int age);
        return (ring_wr + DEPTH - age - 1) % DEPTH;
    endfunction

    // Applies one transaction to the ring model; returns 1 when it yields a result.
    function automatic logic predict_window_stats(input logic [0:0] mode,
                                                  input logic [SAMPLE_W-1:0] cpu,
                                                  input logic [SAMPLE_W-1:0] mem,
                                                  input logic [WINDOW_W-1:0] window,
                                                  input logic [AGE_W-1:0] age,
                                                  output window_stats_t stats);
        int interval;
        int n;
        int i;
        int sum_c;
        int sum_m;
        int th;
        int d1;
        int d2;
        stats = '0;
        stats.trend_code = TREND_NA;
        if (mode == MODE_RECORD)
        begin
            ring_cpu[ring_wr] = cpu;
            ring_mem[ring_wr] = mem;
            ring_wr = (ring_wr + 1) % DEPTH;
            if (ring_fill < DEPTH)
                ring_fill++;
            return 1'b0;
        end
        if (ring_fill > 0)
        begin
            interval = (cfg_interval == '0) ? 1 : int'(cfg_interval);
            n = int'(window) / interval;
            if (n == 0)
                n = 1;
            if (n > ring_fill)
                n = ring_fill;
            sum_c = 0;
            sum_m = 0;
            for (i = 0; i < n; i++)
            begin
                sum_c += int'(ring_cpu[age_slot(i)]);
                sum_m += int'(ring_mem[age_slot(i)]);
            end
            stats.avg_cpu   = 16'(sum_c / n);
            stats.avg_mem   = 16'(sum_m / n);
            stats.avg_valid = 1'b1;
        end
        if (ring_fill >= TREND_SAMPLES)
        begin
            d1 = int'(ring_mem[age_slot(0)]) - int'(ring_mem[age_slot(1)]);
            d2 = int'(ring_mem[age_slot(1)]) - int'(ring_mem[age_slot(2)]);
            th = int'(cfg_threshold);
            if (d1 > th && d2 > th)
                stats.trend_code = TREND_INC;
            else if (d1 < -th && d2 < -th)
                stats.trend_code = TREND_DEC;
            else
                stats.trend_code = TREND_FLAT;
        end
        if (int'(age) < ring_fill)
        begin
            stats.entry_cpu   = ring_cpu[age_slot(int'(age))];
            stats.entry_mem   = ring_mem[age_slot(int'(age))];
            stats.entry_valid = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic stim_row_t stim_row(input logic [0:0] mode,
                                           input logic [SAMPLE_W-1:0] cpu,
                                           input logic [SAMPLE_W-1:0] mem,
                                           input logic [WINDOW_W-1:0] window,
                                           input logic [AGE_W-1:0] age,
                                           input logic has_golden,
                                           input window_stats_t golden);
        return {mode, cpu, mem, window, age, has_golden, golden};
    endfunction

    task automatic send_item(input stim_row_t item);
        window_stats_t predicted;
        logic          produces;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, item.age, item.window, item.mem, item.cpu};
        s_axis_tuser  <= item.mode;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        produces = predict_window_stats(item.mode, item.cpu, item.mem, item.window,
                                        item.age, predicted);
        if (item.mode == MODE_RECORD)
            n_records++;
        else
            n_queries++;
        if (produces)
            expected_stats.push_back(item.has_golden ? item.golden : predicted);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Records mostly follow memory ramps sized around the trend threshold.
    task automatic random_item();
        logic [0:0]          mode;
        logic [SAMPLE_W-1:0] cpu;
        logic [WINDOW_W-1:0] window;
        int                  eff;
        int                  base;
        int                  step;
        int                  next;
        int                  pick;
        eff  = (cfg_interval == '0) ? 1 : int'(cfg_interval);
        mode = ($urandom_range(0, 9) < 6) ? MODE_RECORD : MODE_QUERY;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            cpu = 16'h0000;
        else if (pick == 1)
            cpu = 16'hFFFF;
        else
            cpu = 16'($urandom);
        if (ramp_left == 0)
        begin
            ramp_dir  = $urandom_range(0, 2);
            ramp_left = $urandom_range(3, 6);
        end
        base = (ring_fill > 0) ? int'(ring_mem[age_slot(0)]) : 0;
        if ($urandom_range(0, 7) == 0)
            step = int'(cfg_threshold);
        else if (cfg_threshold > 16'd60000)
            step = $urandom_range(0, 65535);
        else
            step = int'(cfg_threshold) + $urandom_range(1, 400);
        case (ramp_dir)
            1:       next = base + step;
            2:       next = base - step;
            default: next = -1;
        endcase
        if (next < 0 || next > 65535)
            next = $urandom_range(0, 65535);
        if (mode == MODE_RECORD)
            ramp_left--;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            window = 16'($urandom_range(0, eff * 8));
        else if (pick < 7)
            window = 16'($urandom_range(0, eff * 70));
        else
            window = 16'($urandom);
        send_item(stim_row(mode, cpu, 16'(next), window, 6'($urandom_range(0, 63)),
                           1'b0, NO_GOLDEN));
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        if (addr == REG_INTERVAL)
            cfg_interval = data[INTERVAL_W-1:0];
        else if (addr == REG_THRESHOLD)
            cfg_threshold = data[THRESH_W-1:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input window_stats_t want,
                                   input window_stats_t got);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
        begin
            $display("MISMATCH (%s) at %0t", what, $realtime);
            $display("  expected avg %0d/%0d v%0b trend %0d entry %0d/%0d v%0b",
                     want.avg_cpu, want.avg_mem, want.avg_valid, want.trend_code,
                     want.entry_cpu, want.entry_mem, want.entry_valid);
            $display("  actual   avg %0d/%0d v%0b trend %0d entry %0d/%0d v%0b",
                     got.avg_cpu, got.avg_mem, got.avg_valid, got.trend_code,
                     got.entry_cpu, got.entry_mem, got.entry_valid);
        end
    endtask

    // result side: check, then decide next tready
    initial
    begin
        window_stats_t got;
        window_stats_t want;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.avg_cpu     = m_axis_tdata[OUT_AVG_CPU_LSB +: SAMPLE_W];
                got.avg_mem     = m_axis_tdata[OUT_AVG_MEM_LSB +: SAMPLE_W];
                got.avg_valid   = m_axis_tdata[OUT_AVG_VALID];
                got.trend_code  = m_axis_tdata[OUT_TREND_LSB +: TREND_W];
                got.entry_cpu   = m_axis_tdata[OUT_ENTRY_CPU_LSB +: SAMPLE_W];
                got.entry_mem   = m_axis_tdata[OUT_ENTRY_MEM_LSB +: SAMPLE_W];
                got.entry_valid = m_axis_tdata[OUT_ENTRY_VALID];
                if (expected_stats.size() == 0)
                    report_mismatch("result with no query pending", '0, got);
                else
                begin
                    want = expected_stats.pop_front();
                    n_checked++;
                    trend_hits[want.trend_code]++;
                    if (got !== want || m_axis_tdata[M_TDATA_W-1:OUT_ENTRY_VALID+1] !== '0)
                        report_mismatch("field or padding", want, got);
                end
            end
            if (hold_served != hold_reqs)
            begin
                hold_served = hold_reqs;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (sink_idle_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog: consecutive cycles without any transaction
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles, %0d results pending",
                 STALL_LIMIT, expected_stats.size());
        $display("** usage_history_window_stats_unit: FAILED **");
        $finish;
    end

    initial
    begin
        stim_row_t           directed [17];
        logic [CFG_DATA_W-1:0] interval_word;
        logic [CFG_DATA_W-1:0] threshold_word;
        int                  count;
        int                  p;
        int                  i;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        ring_wr       = 0;
        ring_fill     = 0;
        cfg_interval  = INTERVAL_RST;
        cfg_threshold = THRESH_RST;
        hold_reqs     = 0;
        hold_served   = 0;
        ramp_dir      = 0;
        ramp_left     = 0;
        n_records     = 0;
        n_queries     = 0;
        n_checked     = 0;
        n_mismatch    = 0;
        n_settings    = 1;
        trend_hits    = '{0, 0, 0, 0};
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;

        // reset settings: interval 5, threshold 100
        directed[0]  = stim_row(MODE_QUERY, 16'hA5A5, 16'h5A5A, 16'd0, 6'd0, 1'b1,
                                EMPTY_STATS);
        directed[1]  = stim_row(MODE_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 1'b1,
                                EMPTY_STATS);
        directed[2]  = stim_row(MODE_RECORD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 1'b0,
                                NO_GOLDEN);
        directed[3]  = stim_row(MODE_QUERY, 16'h0000, 16'h0000, 16'd0, 6'd0, 1'b1,
                                {16'hFFFF, 16'hFFFF, 1'b1, TREND_NA,
                                 16'hFFFF, 16'hFFFF, 1'b1});
        directed[4]  = stim_row(MODE_QUERY, 16'h1234, 16'h4321, 16'hFFFF, 6'd1, 1'b1,
                                {16'hFFFF, 16'hFFFF, 1'b1, TREND_NA,
                                 16'h0000, 16'h0000, 1'b0});
        directed[5]  = stim_row(MODE_RECORD, 16'h0000, 16'h0000, 16'd0, 6'd0, 1'b0,
                                NO_GOLDEN);
        directed[6]  = stim_row(MODE_QUERY, 16'hA5A5, 16'h5A5A, 16'd10, 6'd1, 1'b1,
                                {16'd32767, 16'd32767, 1'b1, TREND_NA,
                                 16'hFFFF, 16'hFFFF, 1'b1});
        directed[7]  = stim_row(MODE_RECORD, 16'd1000, 16'd1000, 16'd7, 6'd9, 1'b0,
                                NO_GOLDEN);
        directed[8]  = stim_row(MODE_QUERY, 16'h0000, 16'h0000, 16'hFFFF, 6'd2, 1'b0,
                                NO_GOLDEN);
        // rising ramp, then a step equal to the threshold, then a falling ramp
        directed[9]  = stim_row(MODE_RECORD, 16'hAAAA, 16'd2000, 16'd0, 6'd0, 1'b0,
                                NO_GOLDEN);
        directed[10] = stim_row(MODE_QUERY, 16'h0000, 16'h0000, 16'd5, 6'd0, 1'b0,
                                NO_GOLDEN);
        directed[11] = stim_row(MODE_RECORD, 16'h5555, 16'd2100, 16'd0, 6'd0, 1'b0,
                                NO_GOLDEN);
        directed[12] = stim_row(MODE_QUERY, 16'h0000, 16'h0000, 16'd15, 6'd3, 1'b0,
                                NO_GOLDEN);
        directed[13] = stim_row(MODE_RECORD, 16'd1234, 16'd1000, 16'd0, 6'd0, 1'b0,
                                NO_GOLDEN);
        directed[14] = stim_row(MODE_RECORD, 16'd4321, 16'd0, 16'd0, 6'd0, 1'b0,
                                NO_GOLDEN);
        directed[15] = stim_row(MODE_QUERY, 16'h0000, 16'h0000, 16'd4, 6'd63, 1'b0,
                                NO_GOLDEN);
        directed[16] = stim_row(MODE_QUERY, 16'h0000, 16'h0000, 16'd20, 6'd4, 1'b0,
                                NO_GOLDEN);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 17; i++)
            send_item(directed[i]);
        s_axis_tvalid <= 1'b0;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            while (expected_stats.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (p)
                0:
                begin
                    interval_word  = 16'h0001;
                    threshold_word = 16'd0;
                    count          = 130;
                end
                1:
                begin
                    interval_word  = 16'hC3FF;
                    threshold_word = 16'hFFFF;
                    count          = 110;
                end
                2:
                begin
                    interval_word  = 16'hAB00;
                    threshold_word = 16'd100;
                    count          = 110;
                end
                3:
                begin
                    interval_word  = {8'($urandom), 8'($urandom_range(1, 255))};
                    threshold_word = 16'($urandom_range(0, 3000));
                    count          = 130;
                end
                default:
                begin
                    interval_word  = 16'h0003;
                    threshold_word = 16'd500;
                    count          = 150;
                end
            endcase
            write_reg(REG_INTERVAL, interval_word);
            write_reg(REG_THRESHOLD, threshold_word);
            n_settings++;
            src_idle_on  = (p == 0 || p == 1 || p == 2);
            sink_idle_on = (p == 0 || p == 1 || p == 3);
            if (p == 0)
                hold_reqs++;
            for (i = 0; i < count; i++)
                random_item();
            s_axis_tvalid <= 1'b0;
        end

        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d records and %0d queries under %0d interval/threshold settings,",
                 n_records, n_queries, n_settings);
        $display("with %0d results checked (trend stable %0d, up %0d, down %0d, unknown %0d).",
                 n_checked, trend_hits[TREND_FLAT], trend_hits[TREND_INC],
                 trend_hits[TREND_DEC], trend_hits[TREND_NA]);
        if (n_mismatch == 0)
            $display("** usage_history_window_stats_unit: PASSED **");
        else
            $display("** usage_history_window_stats_unit: FAILED **");
        $finish;
    end

endmodule
